### design/llh_pkg.sv
// Shared constants, bucket tables and control types for the latency histogram.
package llh_pkg;

    localparam int BUCKETS = 64;
    localparam longint MAX_US = 1000000;
    localparam int NB = BUCKETS - 1;
    localparam int IDX_W = $clog2(BUCKETS);
    localparam int CUM_W = 32 + IDX_W;
    localparam int PROD_W = CUM_W + 7;
    localparam int TGT_W = 39;
    localparam int DVD_W = 72;
    localparam int DIV_CNT_W = 7;
    localparam int BIG_W = 32 * NB + 64;

    // Percentile numerators over a denominator of one hundred
    localparam int PCT_MED = 50;
    localparam int PCT_P95 = 95;
    localparam int PCT_P99 = 99;
    localparam int PCT_DEN = 100;

    localparam int IN_W = 64;
    localparam int OUT_W = 232;

    typedef logic [31:0] tab_t [BUCKETS];

    typedef struct packed {
        logic load_in;
        logic snap_start;
        logic rec_read;
        logic bucket_write;
        logic scan_issue;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic scan_last;
        logic div_done;
    } status_t;

    // Raise base to the power e with wide integers
    function automatic logic [BIG_W-1:0] big_pow(input longint base, input int e);
        logic [BIG_W-1:0] r;
        r = BIG_W'(1);
        for (int k = 0; k < e; k++)
        begin
            r = r * BIG_W'(base);
        end
        return r;
    endfunction

    // Build thresholds (x^n >= MAX^i) or lower bounds (x^n <= MAX^i)
    function automatic tab_t build_tab(input bit want_thresh);
        tab_t t;
        longint lo;
        longint hi;
        longint mid;
        longint prev;
        logic [BIG_W-1:0] a;
        logic [BIG_W-1:0] b;
        t[0] = 32'd0;
        prev = 1;
        for (int i = 1; i < BUCKETS; i++)
        begin
            a = big_pow(MAX_US, i);
            lo = prev;
            hi = MAX_US;
            while (lo < hi)
            begin
                mid = lo + ((hi - lo + 1) >> 1);
                b = big_pow(mid, NB);
                if (b <= a)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            b = big_pow(lo, NB);
            if (!want_thresh || b == a || lo >= MAX_US)
                t[i] = 32'(lo);
            else
                t[i] = 32'(lo + 1);
            prev = lo;
        end
        return t;
    endfunction

    localparam tab_t THRESH_TAB = build_tab(1'b1);
    localparam tab_t LOWER_TAB = build_tab(1'b0);

    // Map a duration to its bucket; thresholds rise, so the last hit wins
    function automatic logic [IDX_W-1:0] bucket_of(input logic [31:0] d);
        logic [IDX_W-1:0] b;
        b = '0;
        for (int i = 1; i < BUCKETS; i++)
        begin
            if (d >= THRESH_TAB[i])
                b = IDX_W'(i);
        end
        return b;
    endfunction

endpackage

### design/llh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module llh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

### design/llh_datapath.sv
// Datapath: histogram store, running totals, percentile scan and mean divider.
module llh_datapath (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [llh_pkg::IN_W-1:0]  s_tdata,
    input  llh_pkg::cmd_t             cmd,
    output llh_pkg::status_t          status,
    output logic [llh_pkg::OUT_W-1:0] m_tdata
);

    logic [31:0] dur_reg;
    logic [31:0] dl_reg;
    logic [llh_pkg::IDX_W-1:0] bucket_reg;
    logic [31:0] total_reg;
    logic [63:0] sum_reg;
    logic [31:0] max_reg;
    logic [31:0] late_reg;
    logic [llh_pkg::BUCKETS-1:0] valid_reg;
    logic [llh_pkg::IDX_W-1:0] idx_reg;
    logic [llh_pkg::IDX_W-1:0] rd_idx_reg;
    logic rd_scan_reg;
    logic [llh_pkg::CUM_W-1:0] cum_reg;
    logic [2:0] got_reg;
    logic [31:0] pct_reg [3];
    logic [llh_pkg::TGT_W-1:0] tgt_reg [3];
    logic [31:0] rem_reg;
    logic [llh_pkg::DVD_W-1:0] dvd_reg;
    logic [llh_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic div_busy_reg;
    logic [llh_pkg::OUT_W-1:0] out_reg;

    logic [llh_pkg::IDX_W-1:0] ram_raddr;
    logic [31:0] ram_rdata;
    logic [31:0] ram_wdata;
    logic [31:0] cur_count;
    logic [31:0] bval;
    logic [llh_pkg::CUM_W-1:0] cum_next;
    logic [llh_pkg::PROD_W-1:0] cum_scaled;
    logic [64:0] sum_wide;
    logic [32:0] rem_sh;
    logic rem_ge;
    logic [32:0] rem_diff;
    logic [39:0] mean_val;

    llh_ram #(
        .WIDTH (32),
        .DEPTH (llh_pkg::BUCKETS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (cmd.bucket_write),
        .waddr (bucket_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Select read address and form the saturating bucket increment
    always_comb
    begin
        ram_raddr = cmd.rec_read ? llh_pkg::bucket_of(dur_reg) : idx_reg;
        cur_count = valid_reg[bucket_reg] ? ram_rdata : 32'd0;
        ram_wdata = (cur_count == 32'hFFFF_FFFF) ? cur_count : cur_count + 32'd1;
        sum_wide = {1'b0, sum_reg} + {33'd0, dur_reg};
    end

    // Accumulate scanned buckets, scaled by the percentile denominator
    always_comb
    begin
        bval = valid_reg[rd_idx_reg] ? ram_rdata : 32'd0;
        cum_next = cum_reg + llh_pkg::CUM_W'(bval);
        cum_scaled = (llh_pkg::PROD_W'(cum_next) << 6) + (llh_pkg::PROD_W'(cum_next) << 5)
                   + (llh_pkg::PROD_W'(cum_next) << 2);
    end

    // One restoring division step
    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[llh_pkg::DVD_W-1]};
        rem_ge = rem_sh >= {1'b0, total_reg};
        rem_diff = rem_sh - {1'b0, total_reg};
        mean_val = (|dvd_reg[llh_pkg::DVD_W-1:40]) ? 40'hFF_FFFF_FFFF : dvd_reg[39:0];
    end

    // Update the running totals and the bucket valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            sum_reg   <= '0;
            max_reg   <= '0;
            late_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.rec_read)
            begin
                if (total_reg != 32'hFFFF_FFFF)
                    total_reg <= total_reg + 32'd1;
                sum_reg <= sum_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_wide[63:0];
                if (dur_reg > max_reg)
                    max_reg <= dur_reg;
                if (dl_reg != 32'd0 && dur_reg > dl_reg && late_reg != 32'hFFFF_FFFF)
                    late_reg <= late_reg + 32'd1;
            end
            if (cmd.bucket_write)
                valid_reg[bucket_reg] <= 1'b1;
        end
    end

    // Hold request payload and bucket index
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dur_reg <= s_tdata[31:0];
            dl_reg  <= s_tdata[63:32];
        end
        if (cmd.rec_read)
            bucket_reg <= llh_pkg::bucket_of(dur_reg);
    end

    // Scan control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_scan_reg <= 1'b0;
            got_reg     <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            rd_scan_reg <= cmd.scan_issue;
            if (cmd.snap_start)
            begin
                idx_reg <= '0;
                got_reg <= '0;
            end
            else
            begin
                if (cmd.scan_issue)
                    idx_reg <= idx_reg + llh_pkg::IDX_W'(1);
                if (rd_scan_reg)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (!got_reg[k] && cum_scaled >= llh_pkg::PROD_W'(tgt_reg[k]))
                            got_reg[k] <= 1'b1;
                    end
                end
            end
        end
    end

    // Scan payload: targets, running sum and captured bounds
    always_ff @(posedge clk)
    begin
        if (cmd.scan_issue)
            rd_idx_reg <= idx_reg;
        if (cmd.snap_start)
        begin
            cum_reg <= '0;
            tgt_reg[0] <= llh_pkg::TGT_W'(total_reg) * llh_pkg::TGT_W'(llh_pkg::PCT_MED);
            tgt_reg[1] <= llh_pkg::TGT_W'(total_reg) * llh_pkg::TGT_W'(llh_pkg::PCT_P95);
            tgt_reg[2] <= llh_pkg::TGT_W'(total_reg) * llh_pkg::TGT_W'(llh_pkg::PCT_P99);
            for (int k = 0; k < 3; k++)
                pct_reg[k] <= 32'd0;
        end
        else if (rd_scan_reg)
        begin
            cum_reg <= cum_next;
            for (int k = 0; k < 3; k++)
            begin
                if (!got_reg[k] && cum_scaled >= llh_pkg::PROD_W'(tgt_reg[k]))
                    pct_reg[k] <= llh_pkg::LOWER_TAB[rd_idx_reg];
            end
        end
    end

    // Divider sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.snap_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= '0;
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg + llh_pkg::DIV_CNT_W'(1);
            if (div_cnt_reg == llh_pkg::DIV_CNT_W'(llh_pkg::DVD_W - 1))
                div_busy_reg <= 1'b0;
        end
    end

    // Divider remainder and quotient shift register
    always_ff @(posedge clk)
    begin
        if (cmd.snap_start)
        begin
            rem_reg <= '0;
            dvd_reg <= {sum_reg, 8'd0};
        end
        else if (div_busy_reg)
        begin
            rem_reg <= rem_ge ? rem_diff[31:0] : rem_sh[31:0];
            dvd_reg <= {dvd_reg[llh_pkg::DVD_W-2:0], rem_ge};
        end
    end

    // Load the result; an empty histogram reports all zero
    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            if (total_reg == 32'd0)
                out_reg <= '0;
            else
                out_reg <= {pct_reg[2], pct_reg[1], pct_reg[0], mean_val,
                            late_reg, max_reg, total_reg};
        end
    end

    assign m_tdata = out_reg;
    assign status.scan_last = (idx_reg == llh_pkg::IDX_W'(llh_pkg::NB));
    assign status.div_done = !div_busy_reg;

endmodule

### design/llh_ctrl.sv
// Controller: sequences record updates, snapshot scans and result hand-off.
module llh_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              req_type,
    input  logic              m_tready,
    input  llh_pkg::status_t  status,
    output logic              s_tready,
    output logic              m_tvalid,
    output llh_pkg::cmd_t     cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REC_RD = 7'b0000010,
        ST_REC_WR = 7'b0000100,
        ST_SCAN   = 7'b0001000,
        ST_TAIL   = 7'b0010000,
        ST_DIVIDE = 7'b0100000,
        ST_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic out_valid_reg;
    logic out_valid_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    if (req_type)
                    begin
                        cmd.snap_start = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                        state_next = ST_REC_RD;
                end
            end
            ST_REC_RD:
            begin
                cmd.rec_read = 1'b1;
                state_next = ST_REC_WR;
            end
            ST_REC_WR:
            begin
                cmd.bucket_write = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                    state_next = ST_TAIL;
            end
            ST_TAIL:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (status.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.result_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Output valid: set on load, drop when the result is taken
    always_comb
    begin
        if (cmd.result_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

### design/log_latency_histogram_core.sv
// Top level of the log-bucket latency histogram with percentile snapshots.
//
// A record request (tuser 0) is accepted, then does one read of the 64-entry
// bucket RAM and one write back of the saturated count. A snapshot request
// (tuser 1) runs the 72-step bit-serial divider that forms the Q8 mean, with
// the bucket scan alongside it, and then waits for the output register to
// drain if it is still full. A result waiting on the output side does not
// block new record requests. Buckets are cleared at reset by per-entry valid
// bits, so no clearing pass is needed.
module log_latency_histogram_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [llh_pkg::IN_W-1:0]  s_tdata,  // elapsed_time[31:0], due_time[63:32]
    input  logic [0:0]                s_tuser,  // req_type[0]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [llh_pkg::OUT_W-1:0] m_tdata   // sample_count[31:0], max_time[63:32],
                                                // late_count[95:64], mean_q8[135:96],
                                                // median_time[167:136], p95_time[199:168],
                                                // p99_time[231:200]
);

    llh_pkg::cmd_t    cmd;
    llh_pkg::status_t status;

    llh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .req_type (s_tuser[0]),
        .m_tready (m_tready),
        .status   (status),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .cmd      (cmd)
    );

    llh_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .cmd     (cmd),
        .status  (status),
        .m_tdata (m_tdata)
    );

    // One request at a time: an accepted request closes the input
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a request is in progress");

    // An empty histogram reports zero everywhere
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[31:0] == 32'd0) |-> (m_tdata[231:32] == '0))
        else $error("empty snapshot with nonzero fields");

    // Percentile bounds are ordered and never exceed the maximum
    a_pct_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[167:136] <= m_tdata[199:168]
                   && m_tdata[199:168] <= m_tdata[231:200]
                   && m_tdata[231:200] <= m_tdata[63:32]))
        else $error("percentile bounds out of order");

endmodule
